// ----- rtl/core/ipgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipgs_pkg
// Types, register codes and gain helpers for the gain-scheduled incremental
// PID fan controller.
// ----------------------------------------------------------------------------
package ipgs_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int DIST_W    = 8;
    localparam int MODE_W    = 2;
    localparam int DRIVE_W   = 8;
    localparam int ERR_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_SP20 = 2'd1,
        MODE_SP30 = 2'd2,
        MODE_SP40 = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 2'd1;

    localparam logic [CFG_W-1:0] DRIVE_FLOOR_RST   = 8'd110;
    localparam logic [CFG_W-1:0] DRIVE_CEILING_RST = 8'd255;

    // Gain given in tenths, scaled to frac fraction bits, halves round up.
    function automatic int gain_q(input int tenths, input int frac);
        return ((tenths << frac) + 5) / 10;
    endfunction

    // Setpoint in cm for each mode.
    function automatic logic [DIST_W-1:0] setpoint_of(input mode_t m);
        logic [DIST_W-1:0] sp;
        case (m)
            MODE_SP20: sp = 8'd20;
            MODE_SP30: sp = 8'd30;
            MODE_SP40: sp = 8'd40;
            default:   sp = 8'd0;
        endcase
        return sp;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/incremental_pid_gain_schedule.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_gain_schedule
// Velocity-form PID on a distance sample with per-mode gains, producing a
// saturated 8-bit fan drive value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries distance_cm and mode. Each
//   accepted transaction yields exactly one output transaction
//   (out_valid/out_ready) carrying drive.
//   A sample lands in the input register at the accepting edge; its result is
//   registered into drive once the output register is empty or being taken. While
//   the receiver keeps up, throughput is one sample per cycle; the limit is the
//   single pass of three constant multiplies, add and clamp that closes the
//   accumulator loop.
//   When the receiver stalls, the result is held and the input register still
//   takes one more sample; in_ready drops only with both stages full.
//   Configuration (cfg_valid/cfg_ready, always ready): index 0 is the drive
//   floor, index 1 the drive ceiling; other indexes are ignored. Write only
//   while the block is idle.
//   Reset clears both error registers and the accumulator, sets floor to 110
//   and ceiling to 255, and empties both stages.
// ----------------------------------------------------------------------------
module incremental_pid_gain_schedule #(
    parameter int FRAC_BITS = ipgs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ipgs_pkg::DIST_W-1:0]     distance_cm,
    input  wire logic [ipgs_pkg::MODE_W-1:0]     mode,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ipgs_pkg::DRIVE_W-1:0]         drive,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ipgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ipgs_pkg::CFG_W-1:0]      cfg_data
);
    import ipgs_pkg::*;

    localparam int ACC_W = DRIVE_W + FRAC_BITS;
    localparam int INC_W = FRAC_BITS + 13;
    localparam int D2_W  = ERR_W + 2;

    localparam logic signed [INC_W-1:0] KP_SP20 = INC_W'(gain_q(20, FRAC_BITS));
    localparam logic signed [INC_W-1:0] KP_SP30 = INC_W'(gain_q(19, FRAC_BITS));
    localparam logic signed [INC_W-1:0] KP_SP40 = INC_W'(gain_q(10, FRAC_BITS));
    localparam logic signed [INC_W-1:0] KI_ALL  = INC_W'(gain_q(4, FRAC_BITS));
    localparam logic signed [INC_W-1:0] KD_SP20 = INC_W'(gain_q(4, FRAC_BITS));
    localparam logic signed [INC_W-1:0] KD_SP3X = INC_W'(gain_q(3, FRAC_BITS));

    // Configuration registers
    logic [CFG_W-1:0] floor_reg;
    logic [CFG_W-1:0] ceil_reg;

    // Input stage
    logic              s1_vld_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    mode_t             s1_mode_reg;

    // Controller state and result
    logic signed [ERR_W-1:0] err1_reg;
    logic signed [ERR_W-1:0] err2_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic                    out_vld_reg;
    logic [DRIVE_W-1:0]      drive_reg;

    logic                    advance;
    logic                    s1_fire;
    logic                    in_fire;

    logic signed [ERR_W-1:0] e0;
    logic signed [ERR_W:0]   d1;
    logic signed [D2_W-1:0]  d2;
    logic signed [INC_W-1:0] kp_sel;
    logic signed [INC_W-1:0] ki_sel;
    logic signed [INC_W-1:0] kd_sel;
    logic signed [INC_W-1:0] inc;
    logic signed [INC_W-1:0] sum;
    logic signed [INC_W-1:0] lo;
    logic signed [INC_W-1:0] hi;
    logic signed [INC_W-1:0] clamp_lo;
    logic signed [INC_W-1:0] clamp_hi;

    logic [ACC_W-1:0]        acc_next;
    logic [DRIVE_W-1:0]      drive_next;
    logic signed [ERR_W-1:0] err1_next;
    logic signed [ERR_W-1:0] err2_next;

    assign advance   = !out_vld_reg || out_ready;
    assign s1_fire   = s1_vld_reg && advance;
    assign in_ready  = !s1_vld_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign drive     = drive_reg;

    // Gain schedule
    always_comb
    begin
        case (s1_mode_reg)
            MODE_SP20:
            begin
                kp_sel = KP_SP20;
                ki_sel = KI_ALL;
                kd_sel = KD_SP20;
            end
            MODE_SP30:
            begin
                kp_sel = KP_SP30;
                ki_sel = KI_ALL;
                kd_sel = KD_SP3X;
            end
            MODE_SP40:
            begin
                kp_sel = KP_SP40;
                ki_sel = KI_ALL;
                kd_sel = KD_SP3X;
            end
            default:
            begin
                kp_sel = '0;
                ki_sel = '0;
                kd_sel = '0;
            end
        endcase
    end

    // Increment, accumulate and saturate
    always_comb
    begin
        e0  = $signed({2'b00, setpoint_of(s1_mode_reg)}) - $signed({2'b00, s1_dist_reg});
        d1  = (ERR_W+1)'(e0) - (ERR_W+1)'(err1_reg);
        d2  = D2_W'(e0) - (D2_W'(err1_reg) <<< 1) + D2_W'(err2_reg);
        inc = kp_sel * INC_W'(d1) + ki_sel * INC_W'(e0) + kd_sel * INC_W'(d2);

        sum = INC_W'($signed({1'b0, acc_reg})) + inc;
        lo  = INC_W'($signed({1'b0, floor_reg, {FRAC_BITS{1'b0}}}));
        hi  = INC_W'($signed({1'b0, ceil_reg, {FRAC_BITS{1'b0}}}));

        // Floor first, then ceiling, so the ceiling wins when they cross
        clamp_lo = (sum < lo) ? lo : sum;
        clamp_hi = (clamp_lo > hi) ? hi : clamp_lo;

        if (s1_mode_reg == MODE_OFF)
        begin
            acc_next   = '0;
            drive_next = '0;
            err1_next  = err1_reg;
            err2_next  = err2_reg;
        end
        else
        begin
            acc_next   = clamp_hi[ACC_W-1:0];
            drive_next = clamp_hi[ACC_W-1:FRAC_BITS];
            err1_next  = e0;
            err2_next  = err1_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= DRIVE_FLOOR_RST;
            ceil_reg  <= DRIVE_CEILING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DRIVE_FLOOR:   floor_reg <= cfg_data;
                REG_DRIVE_CEILING: ceil_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            err1_reg    <= '0;
            err2_reg    <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                s1_vld_reg <= 1'b1;
            else if (advance)
                s1_vld_reg <= 1'b0;

            if (s1_fire)
            begin
                out_vld_reg <= 1'b1;
                err1_reg    <= err1_next;
                err2_reg    <= err2_next;
                acc_reg     <= acc_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_dist_reg <= distance_cm;
            s1_mode_reg <= mode_t'(mode);
        end
        if (s1_fire)
            drive_reg <= drive_next;
    end

    // Checks
    a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_mode_reg == MODE_OFF) |=> (drive_reg == '0 && acc_reg == '0))
        else $error("off mode did not clear drive");

    a_off_holds_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_mode_reg == MODE_OFF) |=> ($stable(err1_reg) && $stable(err2_reg)))
        else $error("off mode changed error history");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_mode_reg != MODE_OFF) |=> (drive_reg <= $past(ceil_reg)))
        else $error("drive above ceiling");

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_mode_reg != MODE_OFF && floor_reg <= ceil_reg)
        |=> (drive_reg >= $past(floor_reg)))
        else $error("drive below floor");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_vld_reg && out_vld_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
